// ===== rtl/sskpos_pkg.sv =====
// Package for the steady-state Kalman position and speed tracker.
// Holds widths, register indexes, microcode types, the microcode ROM and arithmetic helpers.
// No dependencies; every other file of the block imports it.
package sskpos_pkg;

	// Data and register widths
	localparam int DATA_W     = 32;
	localparam int RES_W      = DATA_W + 1;
	localparam int INTERVAL_W = 24;
	localparam int GAIN_W     = 17;
	localparam int COEF_W     = INTERVAL_W + 1;
	localparam int PROD_W     = RES_W + COEF_W;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = INTERVAL_W;
	localparam int STEP_W     = 4;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SPEED      = 2'd2;

	// Register reset values
	localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 24'd655;
	localparam logic [GAIN_W-1:0]     GAIN_POSITION_RST   = 17'd10262;
	localparam logic [GAIN_W-1:0]     GAIN_SPEED_RST      = 17'd6019;

	// Speed output scale
	localparam logic signed [COEF_W-1:0] SPEED_SCALE = 25'sd1000;

	typedef logic [STEP_W-1:0] step_t;

	// Multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SPD_DT,
		MUL_RES_GPOS,
		MUL_RES_GSPD,
		MUL_SPD_SCALE
	} mul_sel_t;

	// Adder and register write selection
	typedef enum logic [2:0] {
		ALU_NONE,
		ALU_PRED,
		ALU_RESID,
		ALU_POS,
		ALU_SPD,
		ALU_OUT
	} alu_op_t;

	// Jump conditions
	typedef enum logic [1:0] {
		COND_NEVER,
		COND_NO_INPUT,
		COND_OUT_FULL
	} cond_t;

	// One control word of the program
	typedef struct packed {
		logic     accept;
		mul_sel_t mul_sel;
		alu_op_t  alu_op;
		cond_t    cond;
		step_t    target;
		logic     last;
	} ucode_t;

	localparam step_t STEP_IDLE = 4'd0;
	localparam step_t STEP_OUT  = 4'd8;
	localparam step_t STEP_LAST = STEP_OUT;

	// Microcode ROM: wait for a sample, predict, take the residual, correct, scale and load the output.
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		w = '{accept: 1'b0, mul_sel: MUL_NONE, alu_op: ALU_NONE, cond: COND_NEVER,
			target: STEP_IDLE, last: 1'b0};
		unique case (s)
			4'd0: begin
				w.accept = 1'b1;
				w.cond   = COND_NO_INPUT;
				w.target = STEP_IDLE;
			end
			4'd1: w.mul_sel = MUL_SPD_DT;
			4'd2: w.alu_op  = ALU_PRED;
			4'd3: w.alu_op  = ALU_RESID;
			4'd4: w.mul_sel = MUL_RES_GPOS;
			4'd5: begin
				w.alu_op  = ALU_POS;
				w.mul_sel = MUL_RES_GSPD;
			end
			4'd6: w.alu_op  = ALU_SPD;
			4'd7: w.mul_sel = MUL_SPD_SCALE;
			4'd8: begin
				w.alu_op = ALU_OUT;
				w.cond   = COND_OUT_FULL;
				w.target = STEP_OUT;
				w.last   = 1'b1;
			end
			default: w.last = 1'b1;
		endcase
		return w;
	endfunction

	// Saturate a product-wide value to signed 32 bits.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-DATA_W:0] top;
		top = v[PROD_W-1:DATA_W-1];
		if (top == '0 || top == '1)
			return v[DATA_W-1:0];
		else if (v[PROD_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// Round a product to nearest, ties toward plus infinity, dropping the fraction bits.
	function automatic logic signed [PROD_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] q;
		q = p + $signed({{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
		return q >>> FRAC_W;
	endfunction

endpackage

// ===== rtl/sskpos_seq.sv =====
// Microcode sequencer of the position and speed tracker.
// Steps through the control program held in sskpos_pkg and drives the datapath control word.
// Depends on sskpos_pkg.
module sskpos_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_full,
	output sskpos_pkg::ucode_t ctrl
);
	import sskpos_pkg::*;

	step_t step_q;
	step_t step_nxt;
	logic  jump;

	// Current control word
	assign ctrl = ucode_rom(step_q);

	// Jump decision and next step
	always_comb begin
		unique case (ctrl.cond)
			COND_NO_INPUT: jump = ~in_valid;
			COND_OUT_FULL: jump = out_full;
			default:       jump = 1'b0;
		endcase
		priority if (jump)
			step_nxt = ctrl.target;
		else if (ctrl.last)
			step_nxt = STEP_IDLE;
		else
			step_nxt = step_q + step_t'(1);
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_nxt;
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST) else $error("step counter left the program");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.accept && in_valid) |=> (step_q == STEP_IDLE + step_t'(1)))
		else $error("accepted sample did not start the program");
	a_out_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_OUT && !out_full) |=> (step_q == STEP_IDLE))
		else $error("result load did not return to idle");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_OUT && out_full) |=> (step_q == STEP_OUT))
		else $error("result step left while output was full");
`endif

endmodule

// ===== rtl/sskpos_dp.sv =====
// Datapath of the position and speed tracker: config registers, state, one shared
// multiplier, one rounding adder with saturation, and the output register.
// Depends on sskpos_pkg.
module sskpos_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sskpos_pkg::ucode_t                    ctrl,
	input  logic                                  in_accept,
	input  logic [sskpos_pkg::DATA_W-1:0]         meas,
	input  logic                                  cfg_wr_en,
	input  logic [sskpos_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sskpos_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  out_full,
	output logic [sskpos_pkg::DATA_W-1:0]         out_pos,
	output logic [sskpos_pkg::DATA_W-1:0]         out_spd
);
	import sskpos_pkg::*;

	logic [INTERVAL_W-1:0]      interval_q;
	logic [GAIN_W-1:0]          gpos_q;
	logic [GAIN_W-1:0]          gspd_q;
	logic signed [DATA_W-1:0]   pos_q;
	logic signed [DATA_W-1:0]   spd_q;
	logic signed [DATA_W-1:0]   meas_q;
	logic signed [DATA_W-1:0]   pred_q;
	logic signed [RES_W-1:0]    resid_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DATA_W-1:0]   out_pos_q;
	logic signed [DATA_W-1:0]   out_spd_q;
	logic                       out_valid_q;

	logic signed [RES_W-1:0]    mul_a;
	logic signed [COEF_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [DATA_W-1:0]   addend;
	logic signed [PROD_W-1:0]   sum;
	logic signed [DATA_W-1:0]   sum_sat;
	logic                       out_load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= SAMPLE_INTERVAL_RST;
			gpos_q     <= GAIN_POSITION_RST;
			gspd_q     <= GAIN_SPEED_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SAMPLE_INTERVAL: interval_q <= cfg_data;
				REG_GAIN_POSITION:   gpos_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_SPEED:      gspd_q     <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Multiplier operand selection
	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_SPD_DT: begin
				mul_a = {spd_q[DATA_W-1], spd_q};
				mul_b = $signed({1'b0, interval_q});
			end
			MUL_RES_GPOS: begin
				mul_a = resid_q;
				mul_b = $signed({{(COEF_W-GAIN_W){1'b0}}, gpos_q});
			end
			MUL_RES_GSPD: begin
				mul_a = resid_q;
				mul_b = $signed({{(COEF_W-GAIN_W){1'b0}}, gspd_q});
			end
			MUL_SPD_SCALE: begin
				mul_a = {spd_q[DATA_W-1], spd_q};
				mul_b = SPEED_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Product register
	always_ff @(posedge clk) begin
		if (ctrl.mul_sel != MUL_NONE)
			prod_q <= mul_p;
	end

	// Rounding adder with saturation
	always_comb begin
		unique case (ctrl.alu_op)
			ALU_PRED: addend = pos_q;
			ALU_POS:  addend = pred_q;
			ALU_SPD:  addend = spd_q;
			default:  addend = '0;
		endcase
	end

	assign sum     = PROD_W'(addend) + round_q(prod_q);
	assign sum_sat = sat32(sum);

	// Filter state: position and speed estimates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			spd_q <= '0;
		end else begin
			if (ctrl.alu_op == ALU_POS)
				pos_q <= sum_sat;
			if (ctrl.alu_op == ALU_SPD)
				spd_q <= sum_sat;
		end
	end

	// Working registers: sample, prediction and residual
	always_ff @(posedge clk) begin
		if (in_accept)
			meas_q <= meas;
		if (ctrl.alu_op == ALU_PRED)
			pred_q <= sum_sat;
		if (ctrl.alu_op == ALU_RESID)
			resid_q <= {meas_q[DATA_W-1], meas_q} - {pred_q[DATA_W-1], pred_q};
	end

	// Output register; holds a result until its transfer completes.
	assign out_full = out_valid_q & ~out_ready;
	assign out_load = (ctrl.alu_op == ALU_OUT) & ~out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q <= pos_q;
			out_spd_q <= sat32(prod_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos   = out_pos_q;
	assign out_spd   = out_spd_q;

endmodule

// ===== rtl/steady_state_kalman_pos_speed_core.sv =====
// Steady-state Kalman (alpha-beta) position and speed tracker, top level.
// Input stream: s_axis_tdata[31:0] is a raw position sample, signed Q16.16.
// Output stream: m_axis_tdata[31:0] is the filtered position and m_axis_tdata[63:32]
// the speed estimate times 1000, both signed Q16.16 and saturated to 32 bits.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index at a clock edge
// (0: sample interval, 1: position gain, 2: speed gain); other indexes are ignored.
// Write registers only while no sample is in flight.
// Timing: a sample transfer starts a nine-step microcode program that runs through
// one shared 33x25 multiplier and one rounding adder; the last step loads the result
// into the output register, and no new sample is taken until the program is idle again.
// s_axis_tready is high only in the idle step of the program.
// Stall: the result waits in an output register while the sequencer goes back to idle
// and takes the next sample; that sample's program holds at its last step until the
// output register is free.
// Reset: arst_n clears the position and speed state to zero, loads the register
// defaults and empties the output register.
// Depends on sskpos_pkg, sskpos_seq and sskpos_dp.
module steady_state_kalman_pos_speed_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,   // [31:0] measured_position
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [63:0]                       m_axis_tdata,   // [31:0] filtered_position,
	                                                          // [63:32] speed_estimate
	input  logic                              cfg_wr_en,
	input  logic [sskpos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sskpos_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sskpos_pkg::*;

	ucode_t              ctrl;
	logic                out_full;
	logic [DATA_W-1:0]   out_pos;
	logic [DATA_W-1:0]   out_spd;

	// Program sequencer
	sskpos_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_full (out_full),
		.ctrl     (ctrl)
	);

	// Arithmetic datapath
	sskpos_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_accept (s_axis_tvalid & ctrl.accept),
		.meas      (s_axis_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_full  (out_full),
		.out_pos   (out_pos),
		.out_spd   (out_spd)
	);

	// Stream ports
	assign s_axis_tready = ctrl.accept;
	assign m_axis_tdata  = {out_spd, out_pos};

endmodule
